>>> sv/assert_macros.svh
// Assertion macros shared by the RTL. Each use names a label, a property body
// and a message, and is clocked on clk_i with the active-low reset disabling it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every rising clock edge outside reset.
`define SDTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SDTQ_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/sdtq_pkg.sv
package sdtq_pkg;

  // Pool size and derived widths.
  localparam int TIMERS    = 16;
  localparam int IDX_W     = $clog2(TIMERS);
  localparam int ID_W      = 4;
  localparam int WORD_W    = 32;
  localparam int MAX_DRAIN = 16;
  localparam int N_W       = $clog2(MAX_DRAIN);

  // Input function codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_ALLOC = 2'd1;
  localparam logic [1:0] FUNC_ARM   = 2'd2;
  localparam logic [1:0] FUNC_FREE  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_ALLOC  = 2'd1;
  localparam logic [1:0] KIND_ARM    = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_REJECT  = 2'd2;

  // Per-timer flag codes.
  localparam logic [1:0] FLAG_FREE  = 2'd0;
  localparam logic [1:0] FLAG_ALLOC = 2'd1;
  localparam logic [1:0] FLAG_USING = 2'd2;

  // Contents of one list position.
  typedef struct packed {
    logic              valid;
    logic              ahead;
    logic [IDX_W-1:0]  id;
    logic [WORD_W-1:0] dl;
    logic [WORD_W-1:0] data;
  } cell_t;

  // Command broadcast to every list position.
  typedef struct packed {
    logic              start;
    logic              upd;
    logic              scan;
    logic              ins;
    logic              pop;
    logic [IDX_W-1:0]  id;
    logic [WORD_W-1:0] dl;
    logic [WORD_W-1:0] data;
  } cell_ctrl_t;

  // Write port of the flag table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [1:0]       flag;
  } flag_wr_t;

endpackage

>>> sv/sdtq_cell.sv
module sdtq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdtq_pkg::cell_ctrl_t ctrl_i,
  input  sdtq_pkg::cell_t    prev_i,
  input  sdtq_pkg::cell_t    next_i,
  output sdtq_pkg::cell_t    cell_o,
  output logic               tok_o,
  output logic               stop_o
);

  logic                        valid_q, valid_d;
  logic                        ahead_q, ahead_d;
  logic [sdtq_pkg::IDX_W-1:0]  id_q, id_d;
  logic [sdtq_pkg::WORD_W-1:0] dl_q, dl_d;
  logic [sdtq_pkg::WORD_W-1:0] data_q, data_d;
  logic                        tok;

  // The scan token sits at the first position whose ahead bit is still set.
  assign tok    = ahead_q & ~prev_i.ahead;
  assign tok_o  = tok;
  assign stop_o = tok & (~valid_q | (dl_q >= ctrl_i.dl));

  always_comb begin
    valid_d = valid_q;
    ahead_d = ahead_q;
    id_d    = id_q;
    dl_d    = dl_q;
    data_d  = data_q;
    if (ctrl_i.start) begin
      ahead_d = 1'b1;
    end
    if (ctrl_i.upd && (id_q == ctrl_i.id)) begin
      dl_d   = ctrl_i.dl;
      data_d = ctrl_i.data;
    end
    if (ctrl_i.scan) begin
      ahead_d = ahead_q & ~tok;
    end else if (ctrl_i.ins) begin
      ahead_d = 1'b0;
      if (tok) begin
        valid_d = 1'b1;
        id_d    = ctrl_i.id;
        dl_d    = ctrl_i.dl;
        data_d  = ctrl_i.data;
      end else if (ahead_q) begin
        valid_d = prev_i.valid;
        id_d    = prev_i.id;
        dl_d    = prev_i.dl;
        data_d  = prev_i.data;
      end
    end else if (ctrl_i.pop) begin
      ahead_d = 1'b0;
      valid_d = next_i.valid;
      id_d    = next_i.id;
      dl_d    = next_i.dl;
      data_d  = next_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ahead_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ahead_q <= ahead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    dl_q   <= dl_d;
    data_q <= data_d;
  end

  assign cell_o = '{valid: valid_q, ahead: ahead_q, id: id_q, dl: dl_q, data: data_q};

endmodule

>>> sv/sdtq_flags.sv
module sdtq_flags (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sdtq_pkg::IDX_W-1:0] rd_idx_i,
  output logic [1:0]                 rd_flag_o,
  input  sdtq_pkg::flag_wr_t         wr_i
);

  logic [1:0] flags_q [sdtq_pkg::TIMERS];

  assign rd_flag_o = flags_q[rd_idx_i];

  // Every timer starts out free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sdtq_pkg::TIMERS; i++) begin
        flags_q[i] <= sdtq_pkg::FLAG_FREE;
      end
    end else if (wr_i.en) begin
      flags_q[wr_i.idx] <= wr_i.flag;
    end
  end

endmodule

>>> sv/sorted_deadline_timer_queue.sv
// One item is in flight at a time. A free only writes the flag table; a tick drains every
// expired timer (up to 16) from the head, one word each, or emits nothing when none is due;
// an allocate scans the flag table one entry at a time; an arm walks the insertion token
// down the list one cell per cycle; output stalls can hold ticks, allocates and arms. Reset
// (rst_ni, asynchronous, active low) empties the list, frees all timers and clears the tick
// counter and the output register; it needs no clearing pass.
module sorted_deadline_timer_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [sdtq_pkg::ID_W-1:0]   timer_id_i,
  input  logic [sdtq_pkg::WORD_W-1:0] delay_ticks_i,
  input  logic [sdtq_pkg::WORD_W-1:0] tag_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [sdtq_pkg::ID_W-1:0]   result_timer_o,
  output logic [sdtq_pkg::WORD_W-1:0] expired_data_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);

  // Sequencer states. IDLE takes a word; TICK drains expired timers from the head of the
  // list; ALLOC walks the flag table; SCAN walks the insertion token down the list; INS
  // shifts the tail and drops the new entry in; RESP waits for room in the output register.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TICK  = 3'd1;
  localparam logic [2:0] ST_ALLOC = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_INS   = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  localparam logic [sdtq_pkg::N_W-1:0]   N_LAST   = sdtq_pkg::N_W'(sdtq_pkg::MAX_DRAIN - 1);
  localparam logic [sdtq_pkg::IDX_W-1:0] IDX_LAST = sdtq_pkg::IDX_W'(sdtq_pkg::TIMERS - 1);

  logic [2:0]                  state_q, state_d;
  logic [sdtq_pkg::WORD_W-1:0] tick_q, tick_d;
  logic [sdtq_pkg::N_W-1:0]    n_q, n_d;
  logic [sdtq_pkg::IDX_W-1:0]  scan_q, scan_d;

  // Latched arm request.
  logic [sdtq_pkg::IDX_W-1:0]  arm_id_q, arm_id_d;
  logic [sdtq_pkg::WORD_W-1:0] arm_dl_q, arm_dl_d;
  logic [sdtq_pkg::WORD_W-1:0] arm_data_q, arm_data_d;

  // Pending single-word answer for allocate and arm.
  logic [1:0]                  resp_kind_q, resp_kind_d;
  logic [sdtq_pkg::ID_W-1:0]   resp_timer_q, resp_timer_d;
  logic [1:0]                  resp_status_q, resp_status_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  out_kind_q, out_kind_d;
  logic [sdtq_pkg::ID_W-1:0]   out_timer_q, out_timer_d;
  logic [sdtq_pkg::WORD_W-1:0] out_data_q, out_data_d;
  logic [1:0]                  out_status_q, out_status_d;
  logic                        out_last_q, out_last_d;

  logic                        accept;
  logic                        load_ok;
  logic                        in_range;
  logic                        arm_ok;
  logic                        list_full;
  logic                        head_due;
  logic                        more_due;
  logic                        stop_any;
  logic [sdtq_pkg::IDX_W-1:0]  rd_idx;
  logic [1:0]                  rd_flag;
  sdtq_pkg::flag_wr_t          flag_wr;
  sdtq_pkg::cell_ctrl_t        ctrl;

  sdtq_pkg::cell_t             cells   [sdtq_pkg::TIMERS];
  sdtq_pkg::cell_t             prev_s  [sdtq_pkg::TIMERS];
  sdtq_pkg::cell_t             next_s  [sdtq_pkg::TIMERS];
  logic [sdtq_pkg::TIMERS-1:0] tok_vec;
  logic [sdtq_pkg::TIMERS-1:0] stop_vec;
  logic [sdtq_pkg::TIMERS-1:0] valid_vec;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  // The output register can take a new word when empty or when its word leaves now.
  assign load_ok = ~out_valid_q | ~out_stall_i;

  assign in_range  = (32'(timer_id_i) < 32'(sdtq_pkg::TIMERS));
  assign list_full = cells[sdtq_pkg::TIMERS-1].valid;
  assign arm_ok    = in_range & (rd_flag != sdtq_pkg::FLAG_USING) & ~list_full;

  // Expiry compares use the already advanced tick count. The second position is looked at
  // one step ahead so that the word leaving now carries the right last marker.
  assign head_due = cells[0].valid & (cells[0].dl <= tick_q);
  assign more_due = cells[1].valid & (cells[1].dl <= tick_q) & (n_q != N_LAST);
  assign stop_any = |stop_vec;

  // The flag table has one read port: the scan index during allocate, the requested timer
  // otherwise (arm checks it in the accept cycle).
  assign rd_idx = (state_q == ST_ALLOC) ? scan_q : sdtq_pkg::IDX_W'(timer_id_i);

  sdtq_flags u_flags (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .rd_flag_o (rd_flag),
    .wr_i      (flag_wr)
  );

  // Broadcast command to the cells. In the accept cycle of an arm that passes its checks,
  // the cells holding the same timer take the new deadline and data word, so a duplicate
  // entry left behind by a free always sees what the timer now holds.
  always_comb begin
    ctrl       = '0;
    ctrl.start = accept & (func_i == sdtq_pkg::FUNC_ARM) & arm_ok;
    ctrl.upd   = ctrl.start;
    ctrl.scan  = (state_q == ST_SCAN) & ~stop_any;
    ctrl.ins   = (state_q == ST_INS);
    ctrl.pop   = (state_q == ST_TICK) & head_due & load_ok;
    if (state_q == ST_IDLE) begin
      ctrl.id   = sdtq_pkg::IDX_W'(timer_id_i);
      ctrl.dl   = tick_q + delay_ticks_i;
      ctrl.data = tag_data_i;
    end else begin
      ctrl.id   = arm_id_q;
      ctrl.dl   = arm_dl_q;
      ctrl.data = arm_data_q;
    end
  end

  // The chain of list cells; position 0 is the head, the earliest deadline.
  for (genvar g = 0; g < sdtq_pkg::TIMERS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_s[g] = '0;
    end else begin : g_mid
      assign prev_s[g] = cells[g-1];
    end
    if (g == sdtq_pkg::TIMERS - 1) begin : g_tail
      assign next_s[g] = '0;
    end else begin : g_body
      assign next_s[g] = cells[g+1];
    end

    sdtq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev_s[g]),
      .next_i (next_s[g]),
      .cell_o (cells[g]),
      .tok_o  (tok_vec[g]),
      .stop_o (stop_vec[g])
    );

    assign valid_vec[g] = cells[g].valid;
  end

  always_comb begin
    state_d       = state_q;
    tick_d        = tick_q;
    n_d           = n_q;
    scan_d        = scan_q;
    arm_id_d      = arm_id_q;
    arm_dl_d      = arm_dl_q;
    arm_data_d    = arm_data_q;
    resp_kind_d   = resp_kind_q;
    resp_timer_d  = resp_timer_q;
    resp_status_d = resp_status_q;
    out_valid_d   = out_valid_q & out_stall_i;
    out_kind_d    = out_kind_q;
    out_timer_d   = out_timer_q;
    out_data_d    = out_data_q;
    out_status_d  = out_status_q;
    out_last_d    = out_last_q;
    flag_wr       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            sdtq_pkg::FUNC_TICK: begin
              tick_d  = tick_q + 1'b1;
              n_d     = '0;
              state_d = ST_TICK;
            end
            sdtq_pkg::FUNC_ALLOC: begin
              scan_d  = '0;
              state_d = ST_ALLOC;
            end
            sdtq_pkg::FUNC_ARM: begin
              arm_id_d     = sdtq_pkg::IDX_W'(timer_id_i);
              arm_dl_d     = ctrl.dl;
              arm_data_d   = tag_data_i;
              resp_kind_d  = sdtq_pkg::KIND_ARM;
              resp_timer_d = timer_id_i;
              if (arm_ok) begin
                flag_wr       = '{en: 1'b1, idx: sdtq_pkg::IDX_W'(timer_id_i),
                                  flag: sdtq_pkg::FLAG_USING};
                resp_status_d = sdtq_pkg::STAT_OK;
                state_d       = ST_SCAN;
              end else begin
                resp_status_d = sdtq_pkg::STAT_REJECT;
                state_d       = ST_RESP;
              end
            end
            sdtq_pkg::FUNC_FREE: begin
              // A pending timer stays in the list and still expires.
              flag_wr = '{en: in_range, idx: sdtq_pkg::IDX_W'(timer_id_i),
                          flag: sdtq_pkg::FLAG_FREE};
            end
            default: ;
          endcase
        end
      end

      ST_TICK: begin
        if (!head_due) begin
          // Only reachable on the first drain step: nothing due, no word.
          state_d = ST_IDLE;
        end else if (load_ok) begin
          out_valid_d  = 1'b1;
          out_kind_d   = sdtq_pkg::KIND_EXPIRY;
          out_timer_d  = sdtq_pkg::ID_W'(cells[0].id);
          out_data_d   = cells[0].data;
          out_status_d = sdtq_pkg::STAT_OK;
          out_last_d   = ~more_due;
          flag_wr      = '{en: 1'b1, idx: cells[0].id, flag: sdtq_pkg::FLAG_ALLOC};
          n_d          = n_q + 1'b1;
          if (!more_due) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_ALLOC: begin
        resp_kind_d = sdtq_pkg::KIND_ALLOC;
        if (rd_flag == sdtq_pkg::FLAG_FREE) begin
          flag_wr       = '{en: 1'b1, idx: scan_q, flag: sdtq_pkg::FLAG_ALLOC};
          resp_timer_d  = sdtq_pkg::ID_W'(scan_q);
          resp_status_d = sdtq_pkg::STAT_OK;
          state_d       = ST_RESP;
        end else if (scan_q == IDX_LAST) begin
          resp_timer_d  = '0;
          resp_status_d = sdtq_pkg::STAT_NO_FREE;
          state_d       = ST_RESP;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      ST_SCAN: begin
        // The token stops at the first entry with an equal or later deadline, or at the
        // first empty position; the list is never full here.
        if (stop_any) begin
          state_d = ST_INS;
        end
      end

      ST_INS: begin
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (load_ok) begin
          out_valid_d  = 1'b1;
          out_kind_d   = resp_kind_q;
          out_timer_d  = resp_timer_q;
          out_data_d   = '0;
          out_status_d = resp_status_q;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      n_q         <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      n_q         <= n_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arm_id_q      <= arm_id_d;
    arm_dl_q      <= arm_dl_d;
    arm_data_q    <= arm_data_d;
    resp_kind_q   <= resp_kind_d;
    resp_timer_q  <= resp_timer_d;
    resp_status_q <= resp_status_d;
    out_kind_q    <= out_kind_d;
    out_timer_q   <= out_timer_d;
    out_data_q    <= out_data_d;
    out_status_q  <= out_status_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign result_timer_o = out_timer_q;
  assign expired_data_o = out_data_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

  `include "assert_macros.svh"

  // Occupied positions always form an unbroken run from the head.
  `SDTQ_ASSERT(a_valid_prefix, (valid_vec & (valid_vec + 1'b1)) == '0, "list has a hole")
  // While scanning, exactly one position holds the insertion token.
  `SDTQ_IMPLY(a_scan_token, state_q == ST_SCAN, $onehot(tok_vec), "scan token lost")
  // An insertion never starts on a full list.
  `SDTQ_IMPLY(a_ins_room, state_q == ST_INS, !valid_vec[sdtq_pkg::TIMERS-1],
              "insert into full list")

endmodule
